FILE: rtl/core/acrq_pkg.sv
// Shared types and constants of the acknowledge-commit report queue.
package acrq_pkg;

  // Input item command codes
  typedef enum logic [2:0] {
    CMD_PUSH  = 3'd0,
    CMD_POLL  = 3'd1,
    CMD_TICK  = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_FIRE  = 3'd4
  } cmd_e;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_PUSH_OK   = 3'd0,
    KIND_PUSH_FAIL = 3'd1,
    KIND_POLL      = 3'd2,
    KIND_TICK      = 3'd3,
    KIND_SYSTICK   = 3'd4,
    KIND_WRITING   = 3'd5,
    KIND_DONE      = 3'd6
  } kind_e;

  // Link status encoding
  typedef enum logic [1:0] {
    LINK_OFFLINE = 2'd0,
    LINK_STANDBY = 2'd1,
    LINK_VOTE    = 2'd2,
    LINK_MASS    = 2'd3
  } link_e;

  // Configuration register indexes (paddr[3:2])
  typedef enum logic [1:0] {
    REG_DEVICE_NUMBER  = 2'd0,
    REG_TIMEOUT_TICKS  = 2'd1,
    REG_MAX_PER_REPORT = 2'd2
  } reg_e;

  localparam logic [4:0]  DEVICE_NUMBER_RST  = 5'd1;
  localparam logic [15:0] TIMEOUT_TICKS_RST  = 16'd100;
  localparam logic [4:0]  MAX_PER_REPORT_RST = 5'd7;
  localparam logic [15:0] SILENCE_MAX        = 16'hFFFF;
  localparam logic [4:0]  REPORT_CAP         = 5'd16;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] packet_data;
    logic [1:0]  poll_status;
    logic        poll_is_ack;
    logic [31:0] ack_bitmap;
  } item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [31:0] packet_out;
    logic        last;
    logic [4:0]  burst_count;
    logic [1:0]  link_status;
    logic        status_changed;
    logic [8:0]  pending_count;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESP,
    ST_BURST
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic emit_single;
    logic emit_burst;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic burst_go;
    logic burst_last;
  } stat_t;

endpackage

FILE: rtl/core/acrq_ctrl.sv
// Sequencer of the report queue: accept, execute, emit.
module acrq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  acrq_pkg::stat_t stat_i,
  output logic            busy_o,
  output acrq_pkg::ctrl_t cmd_o
);

  acrq_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= acrq_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      acrq_pkg::ST_IDLE: begin
        if (start_i) state_d = acrq_pkg::ST_EXEC;
      end
      acrq_pkg::ST_EXEC: begin
        state_d = stat_i.burst_go ? acrq_pkg::ST_BURST : acrq_pkg::ST_RESP;
      end
      acrq_pkg::ST_RESP: begin
        state_d = acrq_pkg::ST_IDLE;
      end
      acrq_pkg::ST_BURST: begin
        if (stat_i.burst_last) state_d = acrq_pkg::ST_IDLE;
      end
      default: state_d = acrq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      acrq_pkg::ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      acrq_pkg::ST_EXEC:  cmd_o.exec        = 1'b1;
      acrq_pkg::ST_RESP:  cmd_o.emit_single = 1'b1;
      acrq_pkg::ST_BURST: cmd_o.emit_burst  = 1'b1;
      default: busy_o = 1'b1;
    endcase
  end

endmodule

FILE: rtl/core/acrq_dp.sv
// Datapath of the report queue: packet memory, pointers, link state, result register.
module acrq_dp #(
  parameter int QUEUE_DEPTH = 256,
  parameter int PACKET_BITS = 32,
  parameter int MAX_BURST   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  acrq_pkg::ctrl_t   cmd_i,
  output acrq_pkg::stat_t   stat_o,
  input  acrq_pkg::item_t   item_i,
  input  logic [4:0]        device_number_i,
  input  logic [15:0]       timeout_ticks_i,
  input  logic [4:0]        max_per_report_i,
  output logic              result_valid_o,
  output acrq_pkg::result_t result_o
);

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;
  localparam logic [4:0] BURST_CAP =
      5'((MAX_BURST < 16) ? MAX_BURST : 16);
  localparam logic [IDX_W:0]   DEPTH_W = (IDX_W + 1)'(QUEUE_DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(QUEUE_DEPTH);

  // Pointer = index into the memory plus a lap bit.
  function automatic logic [IDX_W:0] advance(input logic [IDX_W-1:0] idx,
                                             input logic ph,
                                             input logic [IDX_W:0] off);
    logic [IDX_W:0] sum;
    logic           ph_n;
    sum  = {1'b0, idx} + off;
    ph_n = ph;
    if (sum >= DEPTH_W) begin
      sum  = sum - DEPTH_W;
      ph_n = ~ph;
    end
    return {ph_n, sum[IDX_W-1:0]};
  endfunction

  logic [PACKET_BITS-1:0] mem [QUEUE_DEPTH];
  logic [PACKET_BITS-1:0] rd_q;

  acrq_pkg::item_t  item_q;
  logic [IDX_W-1:0] head_q, head_d, tail_q, tail_d;
  logic             hph_q, hph_d, tph_q, tph_d;
  logic [4:0]       burst_q, burst_d;
  logic [15:0]      sil_q, sil_d;
  logic [1:0]       now_q, now_d, rep_q, rep_d;
  logic             armed_q, armed_d;
  logic [4:0]       cnt_q;
  logic [2:0]       kind_q, kind_d;
  logic             chg_q, chg_d;

  logic             res_valid_q;
  logic             pkt_sel_q;
  logic [2:0]       res_kind_q;
  logic             res_last_q;
  logic [4:0]       res_burst_q;
  logic [1:0]       res_link_q;
  logic             res_chg_q;
  logic [8:0]       res_pend_q;

  logic [CNT_W-1:0] pend;
  logic             full;
  logic [4:0]       cap;
  logic [4:0]       n_burst;
  logic [4:0]       n_commit;
  logic [IDX_W:0]   tail_adv;
  logic [IDX_W:0]   rd_ptr;
  logic [15:0]      sil_inc;
  logic             is_fire_burst;
  logic [63:0]      rd_wide;

  assign pend = CNT_W'(head_q) - CNT_W'(tail_q) + ((hph_q != tph_q) ? DEPTH_C : '0);
  assign full = (pend == DEPTH_C);

  assign cap     = (max_per_report_i < BURST_CAP) ? max_per_report_i : BURST_CAP;
  assign n_burst = (CMP_W'(pend) < CMP_W'(cap)) ? 5'(pend) : cap;
  assign n_commit = (CMP_W'(pend) < CMP_W'(burst_q)) ? 5'(pend) : burst_q;

  assign tail_adv = advance(tail_q, tph_q, (IDX_W + 1)'(n_commit));
  assign rd_ptr   = advance(tail_q, tph_q, (IDX_W + 1)'(cnt_q));
  assign sil_inc  = (sil_q != acrq_pkg::SILENCE_MAX) ? sil_q + 16'd1 : sil_q;

  assign is_fire_burst = (item_q.command == acrq_pkg::CMD_FIRE) && armed_q &&
                         (now_q == acrq_pkg::LINK_MASS);

  assign stat_o.burst_go   = is_fire_burst && (n_burst != 5'd0);
  assign stat_o.burst_last = ((cnt_q + 5'd1) == burst_q);

  // Next state of one executed item
  always_comb begin
    head_d  = head_q;
    hph_d   = hph_q;
    tail_d  = tail_q;
    tph_d   = tph_q;
    burst_d = burst_q;
    sil_d   = sil_q;
    now_d   = now_q;
    rep_d   = rep_q;
    armed_d = armed_q;
    kind_d  = acrq_pkg::KIND_DONE;
    chg_d   = 1'b0;
    unique case (item_q.command)
      acrq_pkg::CMD_PUSH: begin
        if (full) begin
          tail_d  = head_q;
          tph_d   = hph_q;
          burst_d = 5'd0;
          kind_d  = acrq_pkg::KIND_PUSH_FAIL;
        end else begin
          {hph_d, head_d} = advance(head_q, hph_q, (IDX_W + 1)'(1));
          kind_d = acrq_pkg::KIND_PUSH_OK;
        end
      end
      acrq_pkg::CMD_POLL: begin
        now_d  = item_q.poll_status;
        sil_d  = 16'd0;
        kind_d = acrq_pkg::KIND_POLL;
        if (((item_q.poll_status == acrq_pkg::LINK_STANDBY) ||
             (item_q.poll_status == acrq_pkg::LINK_MASS)) && item_q.poll_is_ack) begin
          armed_d = 1'b1;
        end else if ((item_q.poll_status == acrq_pkg::LINK_MASS) &&
                     item_q.ack_bitmap[device_number_i]) begin
          {tph_d, tail_d} = tail_adv;
          burst_d = 5'd0;
        end
      end
      acrq_pkg::CMD_TICK: begin
        sil_d  = sil_inc;
        chg_d  = (now_q != rep_q);
        rep_d  = now_q;
        kind_d = acrq_pkg::KIND_TICK;
        if (sil_inc > timeout_ticks_i) begin
          now_d   = acrq_pkg::LINK_OFFLINE;
          head_d  = '0;
          hph_d   = 1'b0;
          tail_d  = '0;
          tph_d   = 1'b0;
          burst_d = 5'd0;
        end
      end
      acrq_pkg::CMD_CLEAR: begin
        head_d  = '0;
        hph_d   = 1'b0;
        tail_d  = '0;
        tph_d   = 1'b0;
        burst_d = 5'd0;
      end
      acrq_pkg::CMD_FIRE: begin
        if (armed_q) begin
          armed_d = 1'b0;
          if (now_q == acrq_pkg::LINK_STANDBY) begin
            kind_d = acrq_pkg::KIND_SYSTICK;
          end else if (now_q == acrq_pkg::LINK_MASS) begin
            burst_d = n_burst;
            kind_d  = acrq_pkg::KIND_WRITING;
          end
        end
      end
      default: kind_d = acrq_pkg::KIND_DONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      hph_q       <= 1'b0;
      tail_q      <= '0;
      tph_q       <= 1'b0;
      burst_q     <= 5'd0;
      sil_q       <= 16'd0;
      now_q       <= acrq_pkg::LINK_OFFLINE;
      rep_q       <= acrq_pkg::LINK_OFFLINE;
      armed_q     <= 1'b0;
      cnt_q       <= 5'd0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.emit_single | cmd_i.emit_burst;
      if (cmd_i.exec) begin
        head_q  <= head_d;
        hph_q   <= hph_d;
        tail_q  <= tail_d;
        tph_q   <= tph_d;
        burst_q <= burst_d;
        sil_q   <= sil_d;
        now_q   <= now_d;
        rep_q   <= rep_d;
        armed_q <= armed_d;
        cnt_q   <= 5'd0;
      end else if (cmd_i.emit_burst) begin
        cnt_q <= cnt_q + 5'd1;
      end
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) item_q <= item_i;
    if (cmd_i.exec) begin
      kind_q <= kind_d;
      chg_q  <= chg_d;
    end
    if (cmd_i.emit_single || cmd_i.emit_burst) begin
      res_link_q <= now_q;
      res_pend_q <= 9'(pend);
    end
    if (cmd_i.emit_single) begin
      pkt_sel_q   <= 1'b0;
      res_kind_q  <= kind_q;
      res_last_q  <= 1'b1;
      res_burst_q <= 5'd0;
      res_chg_q   <= chg_q;
    end else if (cmd_i.emit_burst) begin
      pkt_sel_q   <= 1'b1;
      res_kind_q  <= acrq_pkg::KIND_WRITING;
      res_last_q  <= stat_o.burst_last;
      res_burst_q <= burst_q;
      res_chg_q   <= 1'b0;
    end
  end

  // Packet memory: written on push, read one burst beat per cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.exec && (item_q.command == acrq_pkg::CMD_PUSH) && !full) begin
      mem[head_q] <= PACKET_BITS'(item_q.packet_data);
    end
    if (cmd_i.emit_burst) begin
      rd_q <= mem[rd_ptr[IDX_W-1:0]];
    end
  end

  assign rd_wide = 64'(rd_q);

  assign result_valid_o          = res_valid_q;
  assign result_o.result_kind    = res_kind_q;
  assign result_o.packet_out     = pkt_sel_q ? rd_wide[31:0] : 32'd0;
  assign result_o.last           = res_last_q;
  assign result_o.burst_count    = res_burst_q;
  assign result_o.link_status    = res_link_q;
  assign result_o.status_changed = res_chg_q;
  assign result_o.pending_count  = res_pend_q;

endmodule

FILE: rtl/core/ack_commit_report_queue_core.sv
// Top level of the acknowledge-commit report queue with its register port.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+-----------------------------
//  item in   | start high, busy low         | item_i   (acrq_pkg::item_t)
//  result    | result_valid_o, one cycle    | result_o (acrq_pkg::result_t)
//  registers | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// An item passes the accept, execute and emit steps; busy drops as its
// last result beat is shown, so the next item can be taken in that cycle.
// In a writing report of n packets, the packet memory's one read port
// delivers one beat per cycle. The receiver cannot stall results.
// Reset clears pointers, link state and the registers; the packet memory
// holds no reset and needs no clearing pass.
module ack_commit_report_queue_core #(
  parameter int QUEUE_DEPTH = 256,
  parameter int PACKET_BITS = 32,
  parameter int MAX_BURST   = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  acrq_pkg::item_t   item_i,
  output logic              result_valid_o,
  output acrq_pkg::result_t result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [4:0]  dev_q;
  logic [15:0] tmo_q;
  logic [4:0]  mpr_q;
  logic        wr_en;

  acrq_pkg::ctrl_t ctrl;
  acrq_pkg::stat_t stat;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_q <= acrq_pkg::DEVICE_NUMBER_RST;
      tmo_q <= acrq_pkg::TIMEOUT_TICKS_RST;
      mpr_q <= acrq_pkg::MAX_PER_REPORT_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        acrq_pkg::REG_DEVICE_NUMBER:  dev_q <= pwdata[4:0];
        acrq_pkg::REG_TIMEOUT_TICKS:  tmo_q <= pwdata[15:0];
        acrq_pkg::REG_MAX_PER_REPORT: mpr_q <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      acrq_pkg::REG_DEVICE_NUMBER:  prdata = {27'd0, dev_q};
      acrq_pkg::REG_TIMEOUT_TICKS:  prdata = {16'd0, tmo_q};
      acrq_pkg::REG_MAX_PER_REPORT: prdata = {27'd0, mpr_q};
      default:                      prdata = 32'd0;
    endcase
  end

  acrq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .busy_o (busy),
    .cmd_o  (ctrl)
  );

  acrq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .PACKET_BITS(PACKET_BITS),
    .MAX_BURST  (MAX_BURST)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (ctrl),
    .stat_o          (stat),
    .item_i          (item_i),
    .device_number_i (dev_q),
    .timeout_ticks_i (tmo_q),
    .max_per_report_i(mpr_q),
    .result_valid_o  (result_valid_o),
    .result_o        (result_o)
  );

endmodule

FILE: sim/tb_ack_commit_report_queue_core.sv
// Self-checking testbench of the acknowledge-commit report queue core.
module tb_ack_commit_report_queue_core;
  timeunit 1ns;
  timeprecision 1ps;

  import acrq_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;

  logic              clk_i          = 1'b0;
  logic              rst_ni         = 1'b0;
  logic              start          = 1'b0;
  logic              busy;
  item_t             item_i         = '0;
  logic              result_valid_o;
  result_t           result_o;
  logic              psel           = 1'b0;
  logic              penable        = 1'b0;
  logic              pwrite         = 1'b0;
  logic [3:0]        paddr          = '0;
  logic [31:0]       pwdata         = '0;
  logic [31:0]       prdata;
  logic              pready;

  ack_commit_report_queue_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Shadow of the queue state and registers
  logic [31:0] pkt_mem [256];
  logic [8:0]  head_ptr   = '0;
  logic [8:0]  tail_ptr   = '0;
  logic [4:0]  burst_open = '0;
  logic [15:0] silence    = '0;
  link_e       link_now   = LINK_OFFLINE;
  link_e       link_seen  = LINK_OFFLINE;
  logic        armed      = 1'b0;
  logic [4:0]  cfg_dev    = DEVICE_NUMBER_RST;
  logic [15:0] cfg_tmo    = TIMEOUT_TICKS_RST;
  logic [4:0]  cfg_max    = MAX_PER_REPORT_RST;

  result_t beats_due [$];
  result_t beat_want;
  int      mismatches = 0;
  int      items_sent = 0;
  int      cycles     = 0;
  bit      quiet      = 1'b0;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("** ack_commit_report_queue_core: FAILED **");
      $finish;
    end
  end

  task automatic note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
  endtask

  task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) note_mismatch(what, want, got);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (beats_due.size() == 0) begin
        note_mismatch("unexpected result beat, kind", '0, result_o.result_kind);
      end else begin
        beat_want = beats_due.pop_front();
        check_field("result_kind", beat_want.result_kind, result_o.result_kind);
        check_field("packet_out", beat_want.packet_out, result_o.packet_out);
        check_field("last", beat_want.last, result_o.last);
        check_field("burst_count", beat_want.burst_count, result_o.burst_count);
        check_field("link_status", beat_want.link_status, result_o.link_status);
        check_field("status_changed", beat_want.status_changed, result_o.status_changed);
        check_field("pending_count", beat_want.pending_count, result_o.pending_count);
      end
    end
  end

  task automatic emit(kind_e k, logic [31:0] pkt, logic lst, logic [4:0] cnt, logic chg);
    result_t r;
    r.result_kind    = k;
    r.packet_out     = pkt;
    r.last           = lst;
    r.burst_count    = cnt;
    r.link_status    = link_now;
    r.status_changed = chg;
    r.pending_count  = head_ptr - tail_ptr;
    beats_due.push_back(r);
  endtask

  task automatic drop_queue();
    head_ptr   = '0;
    tail_ptr   = '0;
    burst_open = '0;
  endtask

  // Advances the shadow state by one item and queues the beats it produces
  task automatic step_send_queue(item_t it);
    logic [8:0] fill;
    logic [8:0] n;
    logic       chg;
    fill = head_ptr - tail_ptr;
    case (it.command)
      CMD_PUSH: begin
        if (fill[8]) begin
          tail_ptr   = head_ptr;
          burst_open = '0;
          emit(KIND_PUSH_FAIL, '0, 1'b1, '0, 1'b0);
        end else begin
          pkt_mem[head_ptr[7:0]] = it.packet_data;
          head_ptr = head_ptr + 9'd1;
          emit(KIND_PUSH_OK, '0, 1'b1, '0, 1'b0);
        end
      end
      CMD_POLL: begin
        link_now = link_e'(it.poll_status);
        silence  = '0;
        if ((link_now == LINK_STANDBY || link_now == LINK_MASS) && it.poll_is_ack) begin
          armed = 1'b1;
        end else if (link_now == LINK_MASS && it.ack_bitmap[cfg_dev]) begin
          n = {4'd0, burst_open};
          if (n > fill) n = fill;
          tail_ptr   = tail_ptr + n;
          burst_open = '0;
        end
        emit(KIND_POLL, '0, 1'b1, '0, 1'b0);
      end
      CMD_TICK: begin
        if (silence != SILENCE_MAX) silence = silence + 16'd1;
        chg       = (link_now != link_seen);
        link_seen = link_now;
        if (silence > cfg_tmo) begin
          link_now = LINK_OFFLINE;
          drop_queue();
        end
        emit(KIND_TICK, '0, 1'b1, '0, chg);
      end
      CMD_CLEAR: begin
        drop_queue();
        emit(KIND_DONE, '0, 1'b1, '0, 1'b0);
      end
      CMD_FIRE: begin
        if (armed && link_now == LINK_STANDBY) begin
          armed = 1'b0;
          emit(KIND_SYSTICK, '0, 1'b1, '0, 1'b0);
        end else if (armed && link_now == LINK_MASS) begin
          armed = 1'b0;
          n = fill;
          if (n > cfg_max) n = cfg_max;
          if (n > REPORT_CAP) n = REPORT_CAP;
          burst_open = n[4:0];
          if (n == 0) begin
            emit(KIND_WRITING, '0, 1'b1, '0, 1'b0);
          end else begin
            for (int i = 0; i < n; i++)
              emit(KIND_WRITING, pkt_mem[8'(tail_ptr + i)], (i == n - 1), n[4:0], 1'b0);
          end
        end else begin
          armed = 1'b0;
          emit(KIND_DONE, '0, 1'b1, '0, 1'b0);
        end
      end
      default: emit(KIND_DONE, '0, 1'b1, '0, 1'b0);
    endcase
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 9);
    if (quiet || r < 6) return 0;
    if (r < 9) return $urandom_range(1, 3);
    return $urandom_range(6, 24);
  endfunction

  // Leaves start high when no gap follows, so back-to-back items keep one assignment
  task automatic send_item(item_t it);
    int gap;
    item_i <= it;
    start  <= 1'b1;
    do @(posedge clk_i); while (busy !== 1'b0);
    step_send_queue(it);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  function automatic item_t make_item(cmd_e c, logic [31:0] data, link_e st, logic ack,
                                      logic [31:0] bm);
    item_t it;
    it.command     = c;
    it.packet_data = data;
    it.poll_status = st;
    it.poll_is_ack = ack;
    it.ack_bitmap  = bm;
    return it;
  endfunction

  function automatic link_e rand_link();
    return link_e'(2'($urandom_range(0, 3)));
  endfunction

  function automatic item_t rand_item(cmd_e c);
    return make_item(c, $urandom, rand_link(), 1'($urandom_range(0, 1)), $urandom);
  endfunction

  function automatic item_t noise_item();
    item_t it;
    it         = rand_item(CMD_PUSH);
    it.command = 3'($urandom_range(0, 7));
    return it;
  endfunction

  task automatic settle();
    start <= 1'b0;
    while (beats_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(reg_e r, logic [31:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_DEVICE_NUMBER: cfg_dev = v[4:0];
      REG_TIMEOUT_TICKS: cfg_tmo = v[15:0];
      default:           cfg_max = v[4:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic apb_check(reg_e r, logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    check_field("register readback", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_regs();
    apb_check(REG_DEVICE_NUMBER, {27'd0, cfg_dev});
    apb_check(REG_TIMEOUT_TICKS, {16'd0, cfg_tmo});
    apb_check(REG_MAX_PER_REPORT, {27'd0, cfg_max});
  endtask

  task automatic set_cfg(logic [4:0] dev, logic [15:0] tmo, logic [4:0] mx);
    settle();
    apb_write(REG_DEVICE_NUMBER, {27'd0, dev});
    apb_write(REG_TIMEOUT_TICKS, {16'd0, tmo});
    apb_write(REG_MAX_PER_REPORT, {27'd0, mx});
    check_regs();
  endtask

  task automatic test_directed();
    logic [31:0] own;
    own = 32'd1 << cfg_dev;
    send_item(make_item(CMD_PUSH, 32'h0000_0000, LINK_OFFLINE, 1'b0, '0));
    send_item(make_item(CMD_PUSH, 32'hFFFF_FFFF, LINK_MASS, 1'b1, '1));
    send_item(make_item(CMD_PUSH, 32'hA5A5_5A5A, LINK_VOTE, 1'b0, 32'h5A5A_A5A5));
    // fire while nothing is armed
    send_item(make_item(CMD_FIRE, '0, LINK_OFFLINE, 1'b0, '0));
    send_item(make_item(CMD_POLL, '0, LINK_STANDBY, 1'b1, '0));
    send_item(make_item(CMD_FIRE, '0, LINK_OFFLINE, 1'b0, '0));
    // ack wins over a set bitmap bit
    send_item(make_item(CMD_POLL, '0, LINK_MASS, 1'b1, '1));
    send_item(make_item(CMD_FIRE, '1, LINK_MASS, 1'b1, '1));
    send_item(make_item(CMD_POLL, '0, LINK_MASS, 1'b0, ~own));
    send_item(make_item(CMD_POLL, '0, LINK_MASS, 1'b0, own));
    // writing report from an empty queue
    send_item(make_item(CMD_POLL, '0, LINK_MASS, 1'b1, '0));
    send_item(make_item(CMD_FIRE, '0, LINK_OFFLINE, 1'b0, '0));
    // vote does not arm
    send_item(make_item(CMD_POLL, '0, LINK_VOTE, 1'b1, '1));
    send_item(make_item(CMD_FIRE, '0, LINK_OFFLINE, 1'b0, '0));
    // armed, then status moves to vote or offline before the fire
    send_item(make_item(CMD_POLL, '0, LINK_MASS, 1'b1, '0));
    send_item(make_item(CMD_POLL, '0, LINK_VOTE, 1'b0, '1));
    send_item(make_item(CMD_FIRE, '0, LINK_OFFLINE, 1'b0, '0));
    send_item(make_item(CMD_POLL, '0, LINK_STANDBY, 1'b1, '0));
    send_item(make_item(CMD_POLL, '0, LINK_OFFLINE, 1'b1, '1));
    send_item(make_item(CMD_FIRE, '0, LINK_OFFLINE, 1'b0, '0));
    send_item(make_item(CMD_POLL, '0, LINK_MASS, 1'b0, '0));
    send_item(make_item(CMD_TICK, '0, LINK_OFFLINE, 1'b0, '0));
    send_item(make_item(CMD_TICK, '1, LINK_MASS, 1'b1, '1));
    send_item(make_item(CMD_PUSH, 32'h1234_5678, LINK_OFFLINE, 1'b0, '0));
    send_item(make_item(CMD_CLEAR, '0, LINK_OFFLINE, 1'b0, '0));
    send_item(make_item(cmd_e'(3'd5), '1, LINK_MASS, 1'b1, '1));
    send_item(make_item(cmd_e'(3'd7), '0, LINK_OFFLINE, 1'b0, '0));
  endtask

  task automatic test_link_timeout();
    set_cfg(5'd31, 16'd1, 5'd7);
    repeat (3) send_item(rand_item(CMD_PUSH));
    send_item(make_item(CMD_POLL, '0, LINK_MASS, 1'b0, '0));
    repeat (3) send_item(rand_item(CMD_TICK));
    set_cfg(5'd31, 16'd2, 5'd7);
    send_item(make_item(CMD_POLL, '0, LINK_STANDBY, 1'b0, '0));
    repeat (4) send_item(rand_item(CMD_TICK));
  endtask

  // Mostly push / arm / fire / commit rounds with random content, some noise
  task automatic run_traffic(int budget);
    int          first;
    int          k;
    logic [31:0] bm;
    first = items_sent;
    while (items_sent - first < budget) begin
      if ($urandom_range(0, 9) < 8) begin
        k = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(0, 5);
        repeat (k) send_item(rand_item(CMD_PUSH));
        if ($urandom_range(0, 4) == 0) begin
          send_item(make_item(CMD_POLL, $urandom, LINK_STANDBY, 1'b1, $urandom));
          send_item(rand_item(CMD_FIRE));
        end
        send_item(make_item(CMD_POLL, $urandom, LINK_MASS, 1'b1, $urandom));
        if ($urandom_range(0, 3) == 0) send_item(rand_item(CMD_TICK));
        send_item(rand_item(CMD_FIRE));
        bm = $urandom;
        bm[cfg_dev] = ($urandom_range(0, 4) != 0);
        send_item(make_item(CMD_POLL, $urandom, LINK_MASS, 1'b0, bm));
      end else begin
        send_item(noise_item());
      end
    end
  endtask

  task automatic test_random_traffic();
    set_cfg(5'd31, 16'hFFFF, 5'd16);
    run_traffic(35);
    set_cfg(5'd0, 16'd1, 5'd1);
    run_traffic(35);
    set_cfg(5'($urandom), 16'($urandom_range(2, 300)), 5'($urandom_range(1, 16)));
    run_traffic(35);
    set_cfg(5'($urandom), 16'($urandom_range(2, 300)), 5'($urandom_range(1, 16)));
    quiet = 1'b1;
    run_traffic(35);
    quiet = 1'b0;
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    check_regs();
    test_directed();
    test_link_timeout();
    test_random_traffic();
    settle();
    if (mismatches == 0) begin
      $display("** ack_commit_report_queue_core: PASSED **");
    end else begin
      $display("** ack_commit_report_queue_core: FAILED **");
    end
    $finish;
  end

endmodule
